[rtl/dwt_pkg.sv]
package dwt_pkg;

    localparam int COORD_W    = 12;
    localparam int SUM_W      = COORD_W + 1;
    localparam int FRAME_W    = 24;
    localparam int KEEP_W     = 8;
    localparam int TRACE_W    = 12;
    localparam int ID_OUT_W   = 10;
    localparam int SLOT_OUT_W = 4;
    localparam int DROP_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [KEEP_W-1:0]  KEEP_RESET  = 8'd10;
    localparam logic [TRACE_W-1:0] TRACE_RESET = 12'd40;

    localparam logic KIND_DETECT = 1'b0;
    localparam logic KIND_AGING  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEEP_LIMIT  = 2'd0,
        CFG_TRACE_WIDTH = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [KEEP_W-1:0]  keep_limit;
        logic [TRACE_W-1:0] trace_width;
    } cfg_t;

    typedef struct packed {
        logic x_in;
        logic y_in;
        logic fresh;
    } match_t;

endpackage

[rtl/detection_window_tracker_top.sv]
// channel | direction | handshake              | word
// --------+-----------+------------------------+--------------------------------------------
// in      | in        | in_valid / in_ready    | kind, box edges, frame_number
// out     | out       | out_valid / out_ready  | track_id, slot_index, matched, table_full,
//         |           |                        | dropped_count
// cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// a new item is taken only once the previous one has left the done state; the slot scan
// makes one table read and one pass of the shared compare unit per slot
// a detection that matches slot j ends the scan early
// reset clears the valid bits, the id counter and the control registers; no clearing pass
// a result waits in the output register; the next item is taken meanwhile, and a
// finished result stalls in the done state until the output register is free
module detection_window_tracker_top #(
    parameter int NUM_SLOTS  = 16,
    parameter int ID_MODULUS = 1000
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             kind,
    input  logic [dwt_pkg::COORD_W-1:0]      left_x,
    input  logic [dwt_pkg::COORD_W-1:0]      top_y,
    input  logic [dwt_pkg::COORD_W-1:0]      right_x,
    input  logic [dwt_pkg::COORD_W-1:0]      bottom_y,
    input  logic [dwt_pkg::FRAME_W-1:0]      frame_number,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [dwt_pkg::ID_OUT_W-1:0]     track_id,
    output logic [dwt_pkg::SLOT_OUT_W-1:0]   slot_index,
    output logic                             matched,
    output logic                             table_full,
    output logic [dwt_pkg::DROP_W-1:0]       dropped_count,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dwt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dwt_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import dwt_pkg::*;

    localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W   = SLOT_W + 1;
    localparam int ID_W    = (ID_MODULUS > 1) ? $clog2(ID_MODULUS) : 1;
    localparam int ENTRY_W = SUM_W + SUM_W + FRAME_W + ID_W;

    localparam logic [CNT_W-1:0] CNT_SLOTS = CNT_W'(NUM_SLOTS);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(NUM_SLOTS - 1);
    localparam logic [ID_W-1:0]  ID_LAST   = ID_W'(ID_MODULUS - 1);

    cfg_t   cfg;
    match_t mres;

    state_t state_reg, state_next;

    logic                 kind_reg, kind_next;
    logic [SUM_W-1:0]     sx_reg, sx_next;
    logic [SUM_W-1:0]     sy_reg, sy_next;
    logic [FRAME_W-1:0]   frame_reg, frame_next;

    logic [CNT_W-1:0]     issue_cnt_reg, issue_cnt_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [SLOT_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                 cmp_last_reg, cmp_last_next;
    logic                 free_found_reg, free_found_next;
    logic [SLOT_W-1:0]    free_idx_reg, free_idx_next;
    logic [DROP_W-1:0]    drop_cnt_reg, drop_cnt_next;

    logic [NUM_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic [ID_W-1:0]      next_id_reg, next_id_next;

    logic [ID_W-1:0]      res_id_reg, res_id_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic                 res_matched_reg, res_matched_next;
    logic                 res_full_reg, res_full_next;
    logic [DROP_W-1:0]    res_drop_reg, res_drop_next;

    logic                    out_valid_reg, out_valid_next;
    logic [ID_OUT_W-1:0]     track_id_reg, track_id_next;
    logic [SLOT_OUT_W-1:0]   slot_index_reg, slot_index_next;
    logic                    matched_reg, matched_next;
    logic                    table_full_reg, table_full_next;
    logic [DROP_W-1:0]       dropped_count_reg, dropped_count_next;

    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic [SUM_W-1:0]     rd_sum_x;
    logic [SUM_W-1:0]     rd_sum_y;
    logic [FRAME_W-1:0]   rd_frame;
    logic [ID_W-1:0]      rd_id;

    logic                 cur_valid;
    logic                 hit;
    logic                 stale;
    logic                 have_free;
    logic [SLOT_W-1:0]    free_sel;
    logic [DROP_W-1:0]    drop_inc;

    dwt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dwt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_cnt_reg[SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_sum_x = ram_rdata[ENTRY_W-1 -: SUM_W];
    assign rd_sum_y = ram_rdata[ENTRY_W-SUM_W-1 -: SUM_W];
    assign rd_frame = ram_rdata[ID_W +: FRAME_W];
    assign rd_id    = ram_rdata[ID_W-1:0];

    dwt_match_unit u_match (
        .cfg         (cfg),
        .entry_sum_x (rd_sum_x),
        .entry_sum_y (rd_sum_y),
        .entry_frame (rd_frame),
        .box_sum_x   (sx_reg),
        .box_sum_y   (sy_reg),
        .frame       (frame_reg),
        .result      (mres)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);

    assign cur_valid = slot_valid_reg[cmp_idx_reg];
    assign hit       = cur_valid && mres.x_in && mres.y_in && mres.fresh;
    assign stale     = cur_valid && !mres.fresh;
    assign have_free = free_found_reg || !cur_valid;
    assign free_sel  = free_found_reg ? free_idx_reg : cmp_idx_reg;
    assign drop_inc  = (drop_cnt_reg == '1) ? drop_cnt_reg : drop_cnt_reg + 1'b1;

    always_comb
    begin
        state_next         = state_reg;
        kind_next          = kind_reg;
        sx_next            = sx_reg;
        sy_next            = sy_reg;
        frame_next         = frame_reg;
        issue_cnt_next     = issue_cnt_reg;
        cmp_vld_next       = cmp_vld_reg;
        cmp_idx_next       = cmp_idx_reg;
        cmp_last_next      = cmp_last_reg;
        free_found_next    = free_found_reg;
        free_idx_next      = free_idx_reg;
        drop_cnt_next      = drop_cnt_reg;
        slot_valid_next    = slot_valid_reg;
        next_id_next       = next_id_reg;
        res_id_next        = res_id_reg;
        res_slot_next      = res_slot_reg;
        res_matched_next   = res_matched_reg;
        res_full_next      = res_full_reg;
        res_drop_next      = res_drop_reg;
        out_valid_next     = out_valid_reg;
        track_id_next      = track_id_reg;
        slot_index_next    = slot_index_reg;
        matched_next       = matched_reg;
        table_full_next    = table_full_reg;
        dropped_count_next = dropped_count_reg;
        ram_we             = 1'b0;
        ram_waddr          = cmp_idx_reg;
        ram_wdata          = {sx_reg, sy_reg, frame_reg, rd_id};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next       = kind;
                    sx_next         = SUM_W'(left_x) + SUM_W'(right_x);
                    sy_next         = SUM_W'(top_y) + SUM_W'(bottom_y);
                    frame_next      = frame_number;
                    issue_cnt_next  = '0;
                    cmp_vld_next    = 1'b0;
                    free_found_next = 1'b0;
                    drop_cnt_next   = '0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // table read one slot ahead of the compare
                if (issue_cnt_reg < CNT_SLOTS)
                begin
                    cmp_vld_next   = 1'b1;
                    cmp_idx_next   = issue_cnt_reg[SLOT_W-1:0];
                    cmp_last_next  = (issue_cnt_reg == CNT_LAST);
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                end

                if (cmp_vld_reg)
                begin
                    if (kind_reg == KIND_AGING)
                    begin
                        if (stale)
                        begin
                            slot_valid_next[cmp_idx_reg] = 1'b0;
                            drop_cnt_next                = drop_inc;
                        end
                        if (cmp_last_reg)
                        begin
                            res_id_next      = '0;
                            res_slot_next    = '0;
                            res_matched_next = 1'b0;
                            res_full_next    = 1'b0;
                            res_drop_next    = stale ? drop_inc : drop_cnt_reg;
                            state_next       = ST_DONE;
                        end
                    end
                    else if (hit)
                    begin
                        // matched window keeps its id
                        ram_we           = 1'b1;
                        ram_waddr        = cmp_idx_reg;
                        ram_wdata        = {sx_reg, sy_reg, frame_reg, rd_id};
                        res_id_next      = rd_id;
                        res_slot_next    = cmp_idx_reg;
                        res_matched_next = 1'b1;
                        res_full_next    = 1'b0;
                        res_drop_next    = '0;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        if (!free_found_reg && !cur_valid)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                        if (cmp_last_reg)
                        begin
                            res_matched_next = 1'b0;
                            res_drop_next    = '0;
                            if (have_free)
                            begin
                                ram_we                    = 1'b1;
                                ram_waddr                 = free_sel;
                                ram_wdata = {sx_reg, sy_reg, frame_reg, next_id_reg};
                                slot_valid_next[free_sel] = 1'b1;
                                next_id_next  = (next_id_reg == ID_LAST) ? '0
                                                                         : next_id_reg + 1'b1;
                                res_id_next   = next_id_reg;
                                res_slot_next = free_sel;
                                res_full_next = 1'b0;
                            end
                            else
                            begin
                                res_id_next   = '0;
                                res_slot_next = '0;
                                res_full_next = 1'b1;
                            end
                            state_next = ST_DONE;
                        end
                    end
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next     = 1'b1;
                    track_id_next      = ID_OUT_W'(res_id_reg);
                    slot_index_next    = SLOT_OUT_W'(res_slot_reg);
                    matched_next       = res_matched_reg;
                    table_full_next    = res_full_reg;
                    dropped_count_next = res_drop_reg;
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_cnt_reg  <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_last_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            drop_cnt_reg   <= '0;
            slot_valid_reg <= '0;
            next_id_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_cnt_reg  <= issue_cnt_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_last_reg   <= cmp_last_next;
            free_found_reg <= free_found_next;
            drop_cnt_reg   <= drop_cnt_next;
            slot_valid_reg <= slot_valid_next;
            next_id_reg    <= next_id_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg          <= kind_next;
        sx_reg            <= sx_next;
        sy_reg            <= sy_next;
        frame_reg         <= frame_next;
        cmp_idx_reg       <= cmp_idx_next;
        free_idx_reg      <= free_idx_next;
        res_id_reg        <= res_id_next;
        res_slot_reg      <= res_slot_next;
        res_matched_reg   <= res_matched_next;
        res_full_reg      <= res_full_next;
        res_drop_reg      <= res_drop_next;
        track_id_reg      <= track_id_next;
        slot_index_reg    <= slot_index_next;
        matched_reg       <= matched_next;
        table_full_reg    <= table_full_next;
        dropped_count_reg <= dropped_count_next;
    end

    assign out_valid     = out_valid_reg;
    assign track_id      = track_id_reg;
    assign slot_index    = slot_index_reg;
    assign matched       = matched_reg;
    assign table_full    = table_full_reg;
    assign dropped_count = dropped_count_reg;

endmodule

[rtl/dwt_ram.sv]
module dwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/dwt_cfg_regs.sv]
module dwt_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [dwt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dwt_pkg::CFG_DATA_W-1:0] cfg_data,
    output dwt_pkg::cfg_t                  cfg
);

    import dwt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEEP_LIMIT:  cfg_next.keep_limit  = cfg_data[KEEP_W-1:0];
                CFG_TRACE_WIDTH: cfg_next.trace_width = cfg_data[TRACE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.keep_limit  <= KEEP_RESET;
            cfg_reg.trace_width <= TRACE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/dwt_match_unit.sv]
module dwt_match_unit (
    input  dwt_pkg::cfg_t                cfg,
    input  logic [dwt_pkg::SUM_W-1:0]    entry_sum_x,
    input  logic [dwt_pkg::SUM_W-1:0]    entry_sum_y,
    input  logic [dwt_pkg::FRAME_W-1:0]  entry_frame,
    input  logic [dwt_pkg::SUM_W-1:0]    box_sum_x,
    input  logic [dwt_pkg::SUM_W-1:0]    box_sum_y,
    input  logic [dwt_pkg::FRAME_W-1:0]  frame,
    output dwt_pkg::match_t              result
);

    import dwt_pkg::*;

    localparam int AGE_W = FRAME_W + 1;

    logic [SUM_W-1:0] lim2;
    logic [SUM_W-1:0] diff_x;
    logic [SUM_W-1:0] diff_y;
    logic [AGE_W-1:0] expiry;

    // centers are coordinate sums, so the bound is doubled
    assign lim2   = {cfg.trace_width, 1'b0};
    assign diff_x = (entry_sum_x >= box_sum_x) ? (entry_sum_x - box_sum_x)
                                               : (box_sum_x - entry_sum_x);
    assign diff_y = (entry_sum_y >= box_sum_y) ? (entry_sum_y - box_sum_y)
                                               : (box_sum_y - entry_sum_y);
    assign expiry = AGE_W'(entry_frame) + AGE_W'(cfg.keep_limit);

    assign result.x_in  = diff_x < lim2;
    assign result.y_in  = diff_y < lim2;
    assign result.fresh = expiry >= AGE_W'(frame);

endmodule

[rtl/dwt_checker.sv]
module dwt_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [dwt_pkg::ID_OUT_W-1:0]    track_id,
    input logic [dwt_pkg::SLOT_OUT_W-1:0]  slot_index,
    input logic                            matched,
    input logic                            table_full,
    input logic [dwt_pkg::DROP_W-1:0]      dropped_count
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(track_id)
            && $stable(slot_index) && $stable(matched) && $stable(table_full)
            && $stable(dropped_count))
        else $error("stalled result changed");

    // busy right after an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accept");

    a_match_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(matched && table_full))
        else $error("matched and full together");

    // full table result carries no window
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> track_id == '0 && slot_index == '0
            && dropped_count == '0)
        else $error("full result carries a window");

    // aging result carries only the drop count
    a_aging_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped_count != '0 |-> track_id == '0 && slot_index == '0
            && !matched && !table_full)
        else $error("aging result carries a window");

endmodule

bind detection_window_tracker_top dwt_checker u_dwt_checker (.*);

[dv/testbench.sv]
module testbench;
    import dwt_pkg::*;

    localparam int SLOTS         = 16;
    localparam int ID_WRAP       = 1000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;
    localparam int LIMIT_CYCLES  = 3_000_000;
    localparam int COORD_MAX     = (1 << COORD_W) - 1;
    localparam int FRAME_MAX     = (1 << FRAME_W) - 1;

    typedef struct {
        logic               kind;
        logic [COORD_W-1:0] left_x;
        logic [COORD_W-1:0] top_y;
        logic [COORD_W-1:0] right_x;
        logic [COORD_W-1:0] bottom_y;
        logic [FRAME_W-1:0] frame;
    } box_word_t;

    typedef struct {
        logic [ID_OUT_W-1:0]   track_id;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic                  matched;
        logic                  table_full;
        logic [DROP_W-1:0]     dropped_count;
    } track_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  kind = 1'b0;
    logic [COORD_W-1:0]    left_x = '0;
    logic [COORD_W-1:0]    top_y = '0;
    logic [COORD_W-1:0]    right_x = '0;
    logic [COORD_W-1:0]    bottom_y = '0;
    logic [FRAME_W-1:0]    frame_number = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [ID_OUT_W-1:0]   track_id;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic                  matched;
    logic                  table_full;
    logic [DROP_W-1:0]     dropped_count;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // tracker state as predicted
    logic                 win_live  [SLOTS];
    logic [SUM_W-1:0]     win_sum_x [SLOTS];
    logic [SUM_W-1:0]     win_sum_y [SLOTS];
    logic [FRAME_W-1:0]   win_seen  [SLOTS];
    logic [ID_OUT_W-1:0]  win_id    [SLOTS];
    int                   id_next = 0;
    logic [KEEP_W-1:0]    keep_frames = KEEP_RESET;
    logic [TRACE_W-1:0]   trace_px = TRACE_RESET;

    box_word_t   pending_boxes[$];
    track_word_t expected_tracks[$];
    box_word_t   cur_box;

    logic in_taken = 1'b0;
    bit   no_idle = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    int   hold_requests = 0;
    int   holds_done = 0;
    int   frame_now = 0;

    int error_count = 0;
    int words_taken = 0;
    int match_count = 0;
    int new_count = 0;
    int full_count = 0;
    int sweep_count = 0;
    int drop_total = 0;
    int id_wraps = 0;
    int cfg_writes = 0;

    detection_window_tracker_top #(
        .NUM_SLOTS  (SLOTS),
        .ID_MODULUS (ID_WRAP)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .left_x        (left_x),
        .top_y         (top_y),
        .right_x       (right_x),
        .bottom_y      (bottom_y),
        .frame_number  (frame_number),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .track_id      (track_id),
        .slot_index    (slot_index),
        .matched       (matched),
        .table_full    (table_full),
        .dropped_count (dropped_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic track_word_t track_step(box_word_t w);
        track_word_t r;
        int sx, sy, lim2, hit, free_slot, drops, dx, dy;
        r = '{default: '0};
        hit = -1;
        free_slot = -1;
        drops = 0;
        if (w.kind == KIND_AGING)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (win_live[i] && int'(win_seen[i]) + int'(keep_frames) < int'(w.frame))
                begin
                    win_live[i] = 1'b0;
                    drops++;
                end
            end
            r.dropped_count = DROP_W'(drops);
            sweep_count++;
            drop_total += drops;
            return r;
        end
        sx = int'(w.left_x) + int'(w.right_x);
        sy = int'(w.top_y) + int'(w.bottom_y);
        lim2 = 2 * int'(trace_px);
        for (int i = 0; i < SLOTS; i++)
        begin
            dx = int'(win_sum_x[i]) - sx;
            dy = int'(win_sum_y[i]) - sy;
            if (hit < 0 && win_live[i] && dx < lim2 && dx > -lim2 && dy < lim2 && dy > -lim2
                && int'(win_seen[i]) + int'(keep_frames) >= int'(w.frame))
                hit = i;
            if (free_slot < 0 && !win_live[i])
                free_slot = i;
        end
        if (hit >= 0)
        begin
            win_sum_x[hit] = SUM_W'(sx);
            win_sum_y[hit] = SUM_W'(sy);
            win_seen[hit] = w.frame;
            r.track_id = win_id[hit];
            r.slot_index = SLOT_OUT_W'(hit);
            r.matched = 1'b1;
            match_count++;
        end
        else if (free_slot < 0)
        begin
            r.table_full = 1'b1;
            full_count++;
        end
        else
        begin
            win_live[free_slot] = 1'b1;
            win_sum_x[free_slot] = SUM_W'(sx);
            win_sum_y[free_slot] = SUM_W'(sy);
            win_seen[free_slot] = w.frame;
            win_id[free_slot] = ID_OUT_W'(id_next);
            r.track_id = ID_OUT_W'(id_next);
            r.slot_index = SLOT_OUT_W'(free_slot);
            if (id_next + 1 >= ID_WRAP)
            begin
                id_next = 0;
                id_wraps++;
            end
            else
                id_next = id_next + 1;
            new_count++;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 24);
        return $urandom_range(30, 100);
    endfunction

    function automatic int clamp_to(int v, int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // input word driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            in_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_boxes.size() > 0)
            begin
                cur_box = pending_boxes.pop_front();
                kind <= cur_box.kind;
                left_x <= cur_box.left_x;
                top_y <= cur_box.top_y;
                right_x <= cur_box.right_x;
                bottom_y <= cur_box.bottom_y;
                frame_number <= cur_box.frame;
                in_valid <= 1'b1;
                gap_left = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            expected_tracks.insert(expected_tracks.size(), track_step(cur_box));
            in_taken = 1'b1;
            words_taken++;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (holds_done != hold_requests)
        begin
            holds_done++;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        track_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_tracks.size() == 0)
            begin
                $error("result word with nothing expected");
                error_count++;
            end
            else
            begin
                want = expected_tracks.pop_front();
                check_field("track_id", 32'(want.track_id), 32'(track_id));
                check_field("slot_index", 32'(want.slot_index), 32'(slot_index));
                check_field("matched", 32'(want.matched), 32'(matched));
                check_field("table_full", 32'(want.table_full), 32'(table_full));
                check_field("dropped_count", 32'(want.dropped_count), 32'(dropped_count));
            end
        end
    end

    task automatic push_box(logic k, int l, int t, int r, int b, logic [FRAME_W-1:0] f);
        box_word_t w;
        w.kind = k;
        w.left_x = COORD_W'(l);
        w.top_y = COORD_W'(t);
        w.right_x = COORD_W'(r);
        w.bottom_y = COORD_W'(b);
        w.frame = f;
        pending_boxes.insert(pending_boxes.size(), w);
    endtask

    task automatic push_noise();
        logic [FRAME_W-1:0] f;
        logic               k;
        f = ($urandom_range(0, 1) == 1) ? FRAME_W'($urandom) : FRAME_W'(frame_now);
        k = ($urandom_range(0, 3) == 0) ? KIND_AGING : KIND_DETECT;
        push_box(k, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                 $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), f);
    endtask

    // moving objects seen frame by frame, most frames closed by an aging sweep
    task automatic add_tracking(int n_words, int max_obj, int step, int noise_pct);
        int ol[24], ot[24], ow[24], oh[24];
        int n_obj, pushed, j;
        n_obj = 0;
        pushed = 0;
        while (pushed < n_words)
        begin
            if (n_obj < max_obj && (n_obj == 0 || $urandom_range(0, 99) < 15))
            begin
                ow[n_obj] = $urandom_range(0, 200);
                oh[n_obj] = $urandom_range(0, 200);
                ol[n_obj] = $urandom_range(0, COORD_MAX - ow[n_obj]);
                ot[n_obj] = $urandom_range(0, COORD_MAX - oh[n_obj]);
                n_obj++;
            end
            if (n_obj > 1 && $urandom_range(0, 99) < 10)
            begin
                j = $urandom_range(0, n_obj - 1);
                ol[j] = ol[n_obj-1];
                ot[j] = ot[n_obj-1];
                ow[j] = ow[n_obj-1];
                oh[j] = oh[n_obj-1];
                n_obj--;
            end
            for (int k = 0; k < n_obj; k++)
            begin
                ol[k] = clamp_to(ol[k] + int'($urandom_range(0, 2 * step)) - step,
                                 COORD_MAX - ow[k]);
                ot[k] = clamp_to(ot[k] + int'($urandom_range(0, 2 * step)) - step,
                                 COORD_MAX - oh[k]);
                if ($urandom_range(0, 99) < 80)
                begin
                    push_box(KIND_DETECT, ol[k], ot[k], ol[k] + ow[k], ot[k] + oh[k],
                             FRAME_W'(frame_now));
                    pushed++;
                end
                if ($urandom_range(0, 99) < noise_pct)
                begin
                    push_noise();
                    pushed++;
                end
            end
            if ($urandom_range(0, 99) < 85)
            begin
                push_box(KIND_AGING, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                         $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                         FRAME_W'(frame_now));
                pushed++;
            end
            if ($urandom_range(0, 99) < 6)
                frame_now += $urandom_range(2, 300);
            else
                frame_now += 1;
            if (frame_now > FRAME_MAX)
                frame_now = $urandom_range(0, 1000);
        end
    endtask

    // fill and flush the table until the id counter has wrapped
    task automatic churn_ids();
        int batch;
        while (id_wraps == 0)
        begin
            batch = ($urandom_range(0, 3) == 0) ? SLOTS + 1 : $urandom_range(4, SLOTS);
            for (int k = 0; k < batch; k++)
                push_box(KIND_DETECT, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                         $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                         FRAME_W'(frame_now));
            push_box(KIND_AGING, 0, 0, 0, 0, FRAME_W'(frame_now + 1));
            frame_now += 2;
            while (pending_boxes.size() != 0 || in_valid)
                @(posedge clk);
        end
    endtask

    task automatic cfg_write(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_KEEP_LIMIT)
            keep_frames = data[KEEP_W-1:0];
        else
            trace_px = data[TRACE_W-1:0];
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_boxes.size() != 0 || in_valid || expected_tracks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        #(LIMIT_CYCLES * 8);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
            win_live[i] = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset config, bounds, lowest-slot priority, stale window
        push_box(KIND_AGING, 0, 0, 0, 0, 0);
        push_box(KIND_DETECT, 0, 0, 0, 0, 0);
        push_box(KIND_DETECT, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
        push_box(KIND_DETECT, 2, 2, 4, 4, 5);
        push_box(KIND_DETECT, 43, 3, 43, 3, 5);
        push_box(KIND_DETECT, 42, 3, 43, 3, 6);
        push_box(KIND_DETECT, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 11);
        push_box(KIND_DETECT, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 11);
        push_box(KIND_AGING, 0, 0, 0, 0, 16);
        wait_idle();

        // zero trace width: nothing matches, table runs full
        cfg_write(CFG_TRACE_WIDTH, '0);
        for (int k = 0; k < 15; k++)
            push_box(KIND_DETECT, 100, 100, 120, 120, 50);
        push_box(KIND_AGING, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, FRAME_W'(FRAME_MAX));
        wait_idle();

        cfg_write(CFG_KEEP_LIMIT, {4'($urandom), 8'd10});
        cfg_write(CFG_TRACE_WIDTH, 12'd40);
        frame_now = 100;
        add_tracking(300, 6, 20, 8);
        hold_requests++;
        wait_idle();

        cfg_write(CFG_KEEP_LIMIT, '1);
        cfg_write(CFG_TRACE_WIDTH, '1);
        frame_now = FRAME_MAX - 400;
        push_box(KIND_DETECT, 0, 0, 0, 0, FRAME_W'(frame_now));
        push_box(KIND_DETECT, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, FRAME_W'(frame_now));
        push_box(KIND_DETECT, 1, 0, 0, 0, FRAME_W'(frame_now));
        add_tracking(150, 4, 500, 10);
        wait_idle();

        no_idle = 1'b1;
        cfg_write(CFG_KEEP_LIMIT, {4'($urandom), 8'($urandom_range(0, 20))});
        cfg_write(CFG_TRACE_WIDTH, 12'($urandom_range(1, 20)));
        frame_now = $urandom_range(0, 1 << 20);
        add_tracking(200, 8, 8, 5);
        wait_idle();
        no_idle = 1'b0;

        // crowded scene, table fills up
        cfg_write(CFG_KEEP_LIMIT, 12'd3);
        cfg_write(CFG_TRACE_WIDTH, 12'd200);
        add_tracking(200, 20, 100, 5);
        hold_requests++;
        wait_idle();

        cfg_write(CFG_KEEP_LIMIT, '0);
        cfg_write(CFG_TRACE_WIDTH, '0);
        // clear windows left with late frame numbers
        push_box(KIND_AGING, 0, 0, 0, 0, FRAME_W'(FRAME_MAX));
        frame_now = 1000;
        churn_ids();
        wait_idle();

        cfg_write(CFG_KEEP_LIMIT, 12'($urandom));
        cfg_write(CFG_TRACE_WIDTH, 12'($urandom));
        frame_now = $urandom_range(0, FRAME_MAX - 100000);
        add_tracking(120, 5, 60, 60);
        wait_idle();

        $display("covered %0d words: %0d matches, %0d new windows, %0d full-table misses",
                 words_taken, match_count, new_count, full_count);
        $display("%0d aging sweeps dropped %0d windows, id wrapped %0d time(s), %0d reg writes",
                 sweep_count, drop_total, id_wraps, cfg_writes);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
rtl/dwt_pkg.sv
rtl/dwt_ram.sv
rtl/dwt_cfg_regs.sv
rtl/dwt_match_unit.sv
rtl/detection_window_tracker_top.sv
rtl/dwt_checker.sv
dv/testbench.sv
